@@ design/fsplink_pkg.sv @@
package fsplink_pkg;

   localparam int unsigned PAYLOAD_DEPTH = 256;
   localparam int unsigned ADDR_W        = $clog2(PAYLOAD_DEPTH);

   // Link byte constants
   localparam logic [7:0] PREAMBLE_0  = 8'h99;
   localparam logic [7:0] PREAMBLE_1  = 8'h66;
   localparam logic [7:0] ACK_BIT     = 8'h80;
   localparam logic [7:0] ACK_ALT     = 8'h81;
   localparam logic [7:0] IDLE_CHECK  = 8'h4B;
   localparam logic [6:0] BLUE_DEVICE = 7'd8;

   // Request commands
   typedef enum logic [1:0] {
      CMD_XFER      = 2'd0,
      CMD_LOAD_DATA = 2'd1,
      CMD_LOAD_HDR  = 2'd2,
      CMD_START     = 2'd3
   } cmd_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_WIDE_MODE   = 3'd0,
      CSR_DEVICE      = 3'd1,
      CSR_IDLE_CODE   = 3'd2,
      CSR_UNKNOWN_CMD = 3'd3,
      CSR_BAD_SUM     = 3'd4,
      CSR_INTERNAL    = 3'd5,
      CSR_START_CMD   = 3'd6,
      CSR_NULL_CMD    = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_INIT   = 4'd0,
      ST_WAIT   = 4'd1,
      ST_HEAD   = 4'd2,
      ST_DATA   = 4'd3,
      ST_DPAD   = 4'd4,
      ST_SUM    = 4'd5,
      ST_ACK    = 4'd6,
      ST_IDLE   = 4'd7,
      ST_RWAIT  = 4'd8,
      ST_RINIT  = 4'd9,
      ST_RSTART = 4'd10,
      ST_RHEAD  = 4'd11,
      ST_RDATA  = 4'd12,
      ST_RDPAD  = 4'd13,
      ST_RSUM   = 4'd14,
      ST_RACK   = 4'd15
   } link_state_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] rx_byte;
      logic [7:0] load_index;
      logic [7:0] load_value;
      logic       session_open;
      logic       cmd_known;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       packet_ready;
   } rsp_type;

   // Payload buffer write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } buf_wr_type;

endpackage

@@ design/framed_serial_packet_link_unit.sv @@
// Framed serial packet link, byte-exchange slave.
// Request channel (req_*): one item per link byte transfer (command 0) or a
// load / start command from the processor (commands 1 to 3). Loads and start
// produce no response; every transfer produces exactly one response item
// (rsp_*) holding the byte to send back and the packet-waiting flag.
// Configuration (csr_*): register writes, always ready; the user must make
// them only while idle; the block does not enforce this. Latency: a
// transfer's response is valid the cycle after its acceptance. Throughput:
// one request per cycle; the next-state logic, one 16-bit add and one payload
// buffer access sit between the state and result registers. The payload
// buffer is read ahead at the next position, so its registered read data is
// ready when the response data phase needs it. When the receiver stalls, the
// response register holds its item and req_ready drops only while that
// register is full and not being taken. Reset: the link returns to its
// initial state, configuration takes its default values and the response
// register empties. Header, footer and payload contents are undefined until loaded or received.
module framed_serial_packet_link_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fsplink_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fsplink_pkg::rsp_type rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [7:0]           csr_data
);

   localparam int unsigned AW = fsplink_pkg::ADDR_W;

   // Configuration registers
   logic       wide_ff;
   logic [7:0] device_ff, idle_ff, unk_ff, bad_ff, int_ff, start_ff, null_ff;

   // Link state
   fsplink_pkg::link_state_type st_ff, st_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  err_ff, err_in;
   logic [6:0]  dev_ff, dev_in;
   logic [7:0]  hdr_ff [4];
   logic [7:0]  hdr_in [4];
   logic [7:0]  ftr_ff [2];
   logic [7:0]  ftr_in [2];

   // Response register
   logic                 rsp_valid_ff;
   fsplink_pkg::rsp_type rsp_ff;

   logic                    take, emit;
   logic [7:0]              tx;
   logic [7:0]              c, pinc, pdec, rack_err;
   logic [15:0]             got;
   fsplink_pkg::buf_wr_type wr;
   logic [7:0]              rd_data;

   assign csr_ready   = 1'b1;
   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign take        = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign c           = req_payload.rx_byte;
   assign pinc        = pos_ff + 8'd1;
   assign pdec        = (pos_ff != 8'd0) ? pos_ff - 8'd1 : pos_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff  <= 1'b0;
         device_ff <= 8'd0;
         idle_ff  <= 8'd210;
         unk_ff   <= 8'd240;
         bad_ff   <= 8'd241;
         int_ff   <= 8'd242;
         start_ff <= 8'd16;
         null_ff  <= 8'd15;
      end else if (csr_valid) begin
         unique case (fsplink_pkg::csr_index_type'(csr_index))
            fsplink_pkg::CSR_WIDE_MODE:   wide_ff   <= csr_data[0];
            fsplink_pkg::CSR_DEVICE:      device_ff <= csr_data;
            fsplink_pkg::CSR_IDLE_CODE:   idle_ff   <= csr_data;
            fsplink_pkg::CSR_UNKNOWN_CMD: unk_ff    <= csr_data;
            fsplink_pkg::CSR_BAD_SUM:     bad_ff    <= csr_data;
            fsplink_pkg::CSR_INTERNAL:    int_ff    <= csr_data;
            fsplink_pkg::CSR_START_CMD:   start_ff  <= csr_data;
            fsplink_pkg::CSR_NULL_CMD:    null_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Next link state and transmit byte for the accepted request
   always_comb begin
      st_in    = st_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      err_in   = err_ff;
      dev_in   = dev_ff;
      hdr_in   = hdr_ff;
      ftr_in   = ftr_ff;
      tx       = idle_ff;
      emit     = 1'b0;
      got      = {ftr_ff[0], c};
      rack_err = (pos_ff == 8'd2) ? c : err_ff;
      wr.en    = 1'b0;
      wr.addr  = pos_ff[AW-1:0];
      wr.data  = c;
      if (take) begin
         unique case (fsplink_pkg::cmd_type'(req_payload.command))
            fsplink_pkg::CMD_LOAD_DATA: begin
               wr.en   = 1'b1;
               wr.addr = req_payload.load_index[AW-1:0];
               wr.data = req_payload.load_value;
            end
            fsplink_pkg::CMD_LOAD_HDR: begin
               if (req_payload.load_index < 8'd4) begin
                  hdr_in[req_payload.load_index[1:0]] = req_payload.load_value;
               end else if (req_payload.load_index < 8'd6) begin
                  ftr_in[req_payload.load_index[0]] = req_payload.load_value;
               end
            end
            fsplink_pkg::CMD_START: begin
               if (st_ff == fsplink_pkg::ST_RWAIT) st_in = fsplink_pkg::ST_RINIT;
            end
            default: begin
               emit = 1'b1;
               unique case (st_ff)
                  // Hunt for the preamble
                  fsplink_pkg::ST_INIT, fsplink_pkg::ST_WAIT: begin
                     st_in = fsplink_pkg::ST_WAIT;
                     if (c == fsplink_pkg::PREAMBLE_0) begin
                        pos_in = 8'd1;
                     end else if (c == fsplink_pkg::PREAMBLE_1 && pos_ff == 8'd1 &&
                                  st_ff == fsplink_pkg::ST_WAIT) begin
                        len_in = 8'd0;
                        sum_in = 16'd0;
                        err_in = 8'd0;
                        pos_in = 8'd0;
                        st_in  = fsplink_pkg::ST_HEAD;
                     end else begin
                        pos_in = 8'd0;
                     end
                  end
                  // Take header bytes and check them on the last one
                  fsplink_pkg::ST_HEAD: begin
                     hdr_in[pos_ff[1:0]] = c;
                     sum_in = sum_ff + {8'd0, c};
                     if (pinc < 8'd4) begin
                        pos_in = pinc;
                     end else begin
                        len_in = c;
                        pos_in = 8'd0;
                        if (hdr_ff[2] != 8'd0) begin
                           st_in = fsplink_pkg::ST_WAIT;
                        end else if (!req_payload.session_open &&
                                     hdr_ff[0] != start_ff) begin
                           dev_in = device_ff[6:0];
                           st_in  = fsplink_pkg::ST_WAIT;
                        end else begin
                           if (!req_payload.session_open) dev_in = device_ff[6:0];
                           if (!req_payload.cmd_known) err_in = unk_ff;
                           st_in = (c != 8'd0) ? fsplink_pkg::ST_DATA : fsplink_pkg::ST_SUM;
                        end
                     end
                  end
                  // Store payload bytes
                  fsplink_pkg::ST_DATA: begin
                     wr.en  = 1'b1;
                     sum_in = sum_ff + {8'd0, c};
                     pos_in = pinc;
                     if (pinc >= len_ff) begin
                        if (wide_ff && pinc[1:0] != 2'd0) begin
                           pos_in = {5'd0, 3'd4 - {1'b0, pinc[1:0]}};
                           st_in  = fsplink_pkg::ST_DPAD;
                        end else begin
                           pos_in = 8'd0;
                           st_in  = fsplink_pkg::ST_SUM;
                        end
                     end
                  end
                  fsplink_pkg::ST_DPAD: begin
                     pos_in = pdec;
                     if (pdec == 8'd0) st_in = fsplink_pkg::ST_SUM;
                  end
                  // Take the checksum and answer with the device id
                  fsplink_pkg::ST_SUM: begin
                     ftr_in[pos_ff[0]] = c;
                     if (pinc >= 8'd2) begin
                        if (got != sum_ff) err_in = bad_ff;
                        pos_in = 8'd0;
                        st_in  = fsplink_pkg::ST_ACK;
                        tx     = {1'b1, dev_ff};
                     end else begin
                        pos_in = pinc;
                     end
                  end
                  fsplink_pkg::ST_ACK: begin
                     if (dev_ff != fsplink_pkg::BLUE_DEVICE && c != fsplink_pkg::ACK_BIT &&
                         c != fsplink_pkg::ACK_ALT) begin
                        st_in = fsplink_pkg::ST_WAIT;
                     end else begin
                        pos_in = 8'd1;
                        st_in  = fsplink_pkg::ST_IDLE;
                        tx     = (err_ff != 8'd0) ? err_ff : (hdr_ff[0] ^ fsplink_pkg::ACK_BIT);
                     end
                  end
                  fsplink_pkg::ST_IDLE: begin
                     if (pos_ff != 8'd0) begin
                        pos_in = pdec;
                     end else if (hdr_ff[0] == null_ff || err_ff != 8'd0 ||
                                  c != fsplink_pkg::IDLE_CHECK) begin
                        st_in  = fsplink_pkg::ST_WAIT;
                        pos_in = (c == fsplink_pkg::PREAMBLE_0) ? 8'd1 : 8'd0;
                     end else begin
                        st_in = fsplink_pkg::ST_RWAIT;
                     end
                  end
                  fsplink_pkg::ST_RWAIT: ;
                  // Send the response preamble
                  fsplink_pkg::ST_RINIT, fsplink_pkg::ST_RSTART: begin
                     if (st_ff == fsplink_pkg::ST_RINIT || pos_ff == 8'd0) begin
                        pos_in = 8'd1;
                        st_in  = fsplink_pkg::ST_RSTART;
                        tx     = fsplink_pkg::PREAMBLE_0;
                     end else begin
                        len_in = hdr_ff[3];
                        err_in = 8'd0;
                        pos_in = 8'd0;
                        st_in  = fsplink_pkg::ST_RHEAD;
                        tx     = fsplink_pkg::PREAMBLE_1;
                     end
                  end
                  fsplink_pkg::ST_RHEAD: begin
                     tx = hdr_ff[pos_ff[1:0]];
                     if (pinc >= 8'd4) begin
                        pos_in = 8'd0;
                        st_in  = (len_ff != 8'd0) ? fsplink_pkg::ST_RDATA
                                                  : fsplink_pkg::ST_RSUM;
                     end else begin
                        pos_in = pinc;
                     end
                  end
                  fsplink_pkg::ST_RDATA: begin
                     tx     = rd_data;
                     pos_in = pinc;
                     if (pinc >= len_ff) begin
                        if (wide_ff && pinc[1:0] != 2'd0) begin
                           pos_in = {5'd0, 3'd4 - {1'b0, pinc[1:0]}};
                           st_in  = fsplink_pkg::ST_RDPAD;
                        end else begin
                           pos_in = 8'd0;
                           st_in  = fsplink_pkg::ST_RSUM;
                        end
                     end
                  end
                  fsplink_pkg::ST_RDPAD: begin
                     tx     = 8'd0;
                     pos_in = pdec;
                     if (pdec == 8'd0) st_in = fsplink_pkg::ST_RSUM;
                  end
                  fsplink_pkg::ST_RSUM: begin
                     tx = ftr_ff[pos_ff[0]];
                     if (pinc >= 8'd2) begin
                        pos_in = 8'd0;
                        st_in  = fsplink_pkg::ST_RACK;
                     end else begin
                        pos_in = pinc;
                     end
                  end
                  // Exchange acknowledgement and resend on a reported error
                  default: begin
                     if (pos_ff == 8'd0) begin
                        pos_in = 8'd1;
                        tx     = {1'b1, dev_ff};
                     end else if (pos_ff == 8'd1) begin
                        pos_in = 8'd2;
                        tx     = 8'd0;
                     end else begin
                        err_in = rack_err;
                        if (wide_ff && pos_ff < 8'd4) begin
                           pos_in = pinc;
                           tx     = 8'd0;
                        end else begin
                           pos_in = 8'd0;
                           if (rack_err == unk_ff || rack_err == bad_ff ||
                               rack_err == int_ff) begin
                              st_in = fsplink_pkg::ST_RSTART;
                           end else begin
                              st_in = fsplink_pkg::ST_WAIT;
                           end
                        end
                     end
                  end
               endcase
            end
         endcase
      end
   end

   // Advance link state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= fsplink_pkg::ST_INIT;
         pos_ff <= 8'd0;
         len_ff <= 8'd0;
         sum_ff <= 16'd0;
         err_ff <= 8'd0;
         dev_ff <= 7'd0;
      end else begin
         st_ff  <= st_in;
         pos_ff <= pos_in;
         len_ff <= len_in;
         sum_ff <= sum_in;
         err_ff <= err_in;
         dev_ff <= dev_in;
      end
   end

   // Header and footer bytes
   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      ftr_ff <= ftr_in;
   end

   // Hold the response until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_ff.tx_byte      <= tx;
         rsp_ff.packet_ready <= (st_in == fsplink_pkg::ST_RWAIT);
      end
   end

   // Payload buffer, read ahead at the next position
   fsplink_buf u_buf (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (pos_in[AW-1:0]),
      .rd_data (rd_data)
   );

endmodule

@@ design/fsplink_buf.sv @@
module fsplink_buf (
   input  logic                              clock,
   input  fsplink_pkg::buf_wr_type           wr,
   input  logic [fsplink_pkg::ADDR_W-1:0]    rd_addr,
   output logic [7:0]                        rd_data
);

   logic [7:0] mem [fsplink_pkg::PAYLOAD_DEPTH];
   logic [7:0] rd_ff;

   // Write, and read with the new byte forwarded on a same-address write
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_ff <= wr.data;
      end else begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule
